@@ rtl/hog_cell_orientation_histogram_defines.svh @@
// Assertion macros for the HOG cell orientation histogram.
`ifndef HOG_CELL_ORIENTATION_HISTOGRAM_DEFINES_SVH
`define HOG_CELL_ORIENTATION_HISTOGRAM_DEFINES_SVH

// Check that the consequent holds in the same cycle.
`define HOG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hog assertion failed in same cycle");

// Check that the consequent holds in the next cycle.
`define HOG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hog assertion failed in next cycle");

`endif

@@ rtl/hog_pkg.sv @@
// Package with constants for the HOG cell orientation histogram.
`timescale 1ns / 1ps
package hog_pkg;
  localparam int BIN_COUNT_DEFAULT = 9;
  localparam int MAG_W             = 16;
  localparam int ANG_W             = 15;
  localparam int ANG_FOLD_W        = 14;
  localparam int HALF_TURN         = 11520;
  localparam int REM_W             = 14;
  localparam int FRAC_W            = 8;
  localparam int RECIP_K           = 11651;
  localparam int RECIP_K_W         = 14;
  localparam int RECIP_SHIFT       = 19;
  localparam int WEIGHT_W          = 25;
  localparam int SUM_W             = 32;
  localparam int BIN_IDX_W         = 4;
  localparam int S_TDATA_W         = 32;
  localparam int M_TDATA_W         = 40;
endpackage

@@ rtl/hog_cell_orientation_histogram.sv @@
// The last pixel of a cell passes stages p1 to p4; the first bin beat is valid once the drain starts.
// Throughput: one pixel per cycle unless stalled, through a four-stage pipeline into the accumulators.
// A cell end hands the sums to a drain buffer that sends BIN_COUNT beats, one per cycle while m_axis_tready is high;
// a second cell end stalls the input until that drain has finished.
// Reset (rst, synchronous): clears pipeline valids, the bin sums and the drain state.
`timescale 1ns / 1ps
`include "hog_cell_orientation_histogram_defines.svh"
module hog_cell_orientation_histogram #(
  parameter int BIN_COUNT = hog_pkg::BIN_COUNT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] magnitude, [30:16] angle, [31] zero
  input  logic [hog_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] bin_index, [35:4] bin_value, [39:36] zero
  output logic [hog_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);
  import hog_pkg::*;

  localparam int IDX_W   = $clog2(BIN_COUNT);
  localparam int POS_W   = $clog2(HALF_TURN * BIN_COUNT);
  localparam int PROD_W  = REM_W + RECIP_K_W;
  localparam int M_PAD_W = M_TDATA_W - BIN_IDX_W - SUM_W;

  logic                  advance;
  logic                  stall;
  logic                  acc_en;

  logic                  p1_valid;
  logic [MAG_W-1:0]      p1_mag;
  logic [ANG_W-1:0]      p1_ang;
  logic                  p1_last;

  logic                  p2_valid;
  logic [MAG_W-1:0]      p2_mag;
  logic [IDX_W-1:0]      p2_lower;
  logic [REM_W-1:0]      p2_rem;
  logic                  p2_last;

  logic                  p3_valid;
  logic [MAG_W-1:0]      p3_mag;
  logic [IDX_W-1:0]      p3_lower;
  logic [FRAC_W-1:0]     p3_frac;
  logic                  p3_last;

  logic                  p4_valid;
  logic [IDX_W-1:0]      p4_lower;
  logic [IDX_W-1:0]      p4_upper;
  logic [WEIGHT_W-1:0]   p4_w_lo;
  logic [WEIGHT_W-1:0]   p4_w_hi;
  logic                  p4_last;

  logic [ANG_FOLD_W-1:0] ang_fold;
  logic [POS_W-1:0]      pos;
  logic [IDX_W-1:0]      lower_next;
  logic [REM_W-1:0]      rem_next;
  logic [PROD_W-1:0]     frac_prod;
  logic [FRAC_W-1:0]     frac_next;
  logic [IDX_W-1:0]      upper_next;
  logic [WEIGHT_W-1:0]   w_lo_next;
  logic [WEIGHT_W-1:0]   w_hi_next;

  logic [SUM_W-1:0]      sums [BIN_COUNT];
  logic [SUM_W-1:0]      sums_next [BIN_COUNT];
  logic [SUM_W-1:0]      drain_sums [BIN_COUNT];
  logic                  drain_active;
  logic [IDX_W-1:0]      drain_idx;
  logic                  drain_done;

  // Stall only when a cell end would overwrite a drain still in progress
  assign drain_done    = m_axis_tready && (drain_idx == IDX_W'(BIN_COUNT - 1));
  assign stall         = p4_valid && p4_last && drain_active && !drain_done;
  assign advance       = !stall;
  assign s_axis_tready = advance;
  assign acc_en        = p4_valid && advance;

  // Stage 2: fold to half turn, scale by bin count, split into bin and remainder
  always_comb begin
    if (p1_ang >= ANG_W'(2 * HALF_TURN)) begin
      ang_fold = ANG_FOLD_W'(p1_ang - ANG_W'(2 * HALF_TURN));
    end else if (p1_ang >= ANG_W'(HALF_TURN)) begin
      ang_fold = ANG_FOLD_W'(p1_ang - ANG_W'(HALF_TURN));
    end else begin
      ang_fold = ANG_FOLD_W'(p1_ang);
    end
    pos        = POS_W'(ang_fold) * POS_W'(BIN_COUNT);
    lower_next = '0;
    rem_next   = REM_W'(pos);
    for (int k = 1; k < BIN_COUNT; k++) begin
      if (pos >= POS_W'(k * HALF_TURN)) begin
        lower_next = IDX_W'(k);
        rem_next   = REM_W'(pos - POS_W'(k * HALF_TURN));
      end
    end
  end

  // Stage 3: fraction is remainder divided by 45, by reciprocal
  assign frac_prod = PROD_W'(p2_rem) * PROD_W'(RECIP_K);
  assign frac_next = frac_prod[RECIP_SHIFT +: FRAC_W];

  // Stage 4: interpolation weights and neighbor bin
  assign w_lo_next  = WEIGHT_W'(p3_mag) * (WEIGHT_W'(1 << FRAC_W) - WEIGHT_W'(p3_frac));
  assign w_hi_next  = WEIGHT_W'(p3_mag) * WEIGHT_W'(p3_frac);
  assign upper_next = (p3_lower == IDX_W'(BIN_COUNT - 1)) ? '0 : IDX_W'(p3_lower + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else if (advance) begin
      p1_valid <= s_axis_tvalid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_mag   <= s_axis_tdata[MAG_W-1:0];
      p1_ang   <= s_axis_tdata[MAG_W +: ANG_W];
      p1_last  <= s_axis_tlast;
      p2_mag   <= p1_mag;
      p2_lower <= lower_next;
      p2_rem   <= rem_next;
      p2_last  <= p1_last;
      p3_mag   <= p2_mag;
      p3_lower <= p2_lower;
      p3_frac  <= frac_next;
      p3_last  <= p2_last;
      p4_lower <= p3_lower;
      p4_upper <= upper_next;
      p4_w_lo  <= w_lo_next;
      p4_w_hi  <= w_hi_next;
      p4_last  <= p3_last;
    end
  end

  // Stage 5: saturating accumulate into the two touched bins
  always_comb begin
    for (int i = 0; i < BIN_COUNT; i++) begin
      logic [SUM_W:0]    total;
      logic [WEIGHT_W-1:0] add;
      add = '0;
      if (p4_lower == IDX_W'(i)) begin
        add = p4_w_lo;
      end else if (p4_upper == IDX_W'(i)) begin
        add = p4_w_hi;
      end
      total = {1'b0, sums[i]} + (SUM_W + 1)'(add);
      sums_next[i] = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
        sums[i] <= '0;
      end
    end else if (acc_en) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
        sums[i] <= p4_last ? '0 : sums_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en && p4_last) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
        drain_sums[i] <= sums_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_active <= 1'b0;
      drain_idx    <= '0;
    end else if (acc_en && p4_last) begin
      drain_active <= 1'b1;
      drain_idx    <= '0;
    end else if (drain_active && m_axis_tready) begin
      if (drain_done) begin
        drain_active <= 1'b0;
        drain_idx    <= '0;
      end else begin
        drain_idx    <= IDX_W'(drain_idx + 1'b1);
      end
    end
  end

  assign m_axis_tvalid = drain_active;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, drain_sums[drain_idx], BIN_IDX_W'(drain_idx)};
  assign m_axis_tlast  = (drain_idx == IDX_W'(BIN_COUNT - 1));

  `HOG_ASSERT_SAME(a_stall_needs_drain, !s_axis_tready, drain_active && p4_valid && p4_last)
  `HOG_ASSERT_NEXT(a_cell_end_starts_drain, acc_en && p4_last,
                   drain_active && drain_idx == '0)
  `HOG_ASSERT_NEXT(a_drain_ends, drain_active && m_axis_tready && m_axis_tlast && !acc_en,
                   !drain_active)
  `HOG_ASSERT_NEXT(a_stall_holds_stage, p4_valid && !s_axis_tready,
                   p4_valid && $stable(p4_lower) && $stable(p4_w_lo))
endmodule

@@ tb/hog_cell_orientation_histogram_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the HOG cell histogram: predicts bin beats from pixel beats and checks them.
module hog_cell_orientation_histogram_checker #(
  parameter int BIN_COUNT = hog_pkg::BIN_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // [15:0] magnitude, [30:16] angle, [31] zero
  input  logic [hog_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] bin_index, [35:4] bin_value, [39:36] zero
  input  logic [hog_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                          m_axis_tlast,
  output int                            error_count,
  output int                            pending_count
);
  import hog_pkg::*;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [SUM_W-1:0]     bin_value;
    logic                 last_bin;
  } bin_beat_t;

  logic [SUM_W-1:0] bin_sums [BIN_COUNT];
  bin_beat_t        expected_bins [$];
  int               errors = 0;

  function automatic logic [SUM_W-1:0] add_saturated(
    input logic [SUM_W-1:0] sum,
    input logic [63:0]      amount
  );
    logic [63:0] total;
    total = {32'd0, sum} + amount;
    return (total > 64'hFFFF_FFFF) ? '1 : total[SUM_W-1:0];
  endfunction

  task automatic accumulate_pixel(
    input logic [MAG_W-1:0] magnitude,
    input logic [ANG_W-1:0] angle,
    input logic             last_of_cell
  );
    int unsigned folded;
    int unsigned position;
    int unsigned lower;
    int unsigned upper;
    int unsigned remainder;
    int unsigned fraction;
    bin_beat_t   beat;
    folded    = angle % HALF_TURN;
    position  = folded * BIN_COUNT;
    lower     = position / HALF_TURN;
    remainder = position % HALF_TURN;
    fraction  = (remainder * 256) / HALF_TURN;
    upper     = (lower + 1 >= BIN_COUNT) ? 0 : lower + 1;
    bin_sums[lower] = add_saturated(bin_sums[lower], 64'(magnitude) * (256 - fraction));
    bin_sums[upper] = add_saturated(bin_sums[upper], 64'(magnitude) * fraction);
    if (last_of_cell) begin
      for (int i = 0; i < BIN_COUNT; i++) begin
        beat.bin_index = i[BIN_IDX_W-1:0];
        beat.bin_value = bin_sums[i];
        beat.last_bin  = (i == BIN_COUNT - 1);
        expected_bins.insert(expected_bins.size(), beat);
        bin_sums[i] = '0;
      end
    end
  endtask

  task automatic check_bin_beat();
    bin_beat_t want;
    bin_beat_t got;
    got.bin_index = m_axis_tdata[BIN_IDX_W-1:0];
    got.bin_value = m_axis_tdata[BIN_IDX_W +: SUM_W];
    got.last_bin  = m_axis_tlast;
    if (expected_bins.size() == 0) begin
      errors++;
      $display("%0t: unexpected bin beat, expected none, got index %0d value %0d last %0b",
               $time, got.bin_index, got.bin_value, got.last_bin);
      return;
    end
    want = expected_bins.pop_front();
    if (got.bin_index !== want.bin_index) begin
      errors++;
      $display("%0t: bin_index expected %0d got %0d", $time, want.bin_index, got.bin_index);
    end
    if (got.bin_value !== want.bin_value) begin
      errors++;
      $display("%0t: bin_value of bin %0d expected %0d got %0d",
               $time, want.bin_index, want.bin_value, got.bin_value);
    end
    if (got.last_bin !== want.last_bin) begin
      errors++;
      $display("%0t: last_bin of bin %0d expected %0b got %0b",
               $time, want.bin_index, want.last_bin, got.last_bin);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BIN_COUNT; i++) bin_sums[i] = '0;
      expected_bins.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_pixel(s_axis_tdata[MAG_W-1:0],
                         s_axis_tdata[MAG_W +: ANG_W], s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_bin_beat();
      end
    end
    error_count   <= errors;
    pending_count <= expected_bins.size();
  end

endmodule

@@ tb/hog_cell_orientation_histogram_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the HOG cell histogram: pixel stimulus, bin receiver and verdict.
module hog_cell_orientation_histogram_test;
  import hog_pkg::*;

  localparam int BIN_COUNT     = BIN_COUNT_DEFAULT;
  localparam int BIN_WIDTH     = HALF_TURN / BIN_COUNT;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PIXELS = 220;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [15:0] magnitude, [30:16] angle, [31] zero
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [3:0] bin_index, [35:4] bin_value, [39:36] zero
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  int error_count;
  int pending_count;
  int cycle_count = 0;
  int pixels_sent = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int rx_hold = 0;
  int rx_wait = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  always #5 clk = ~clk;

  hog_cell_orientation_histogram #(
    .BIN_COUNT(BIN_COUNT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  hog_cell_orientation_histogram_checker #(
    .BIN_COUNT(BIN_COUNT)
  ) i_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[hog_cell_orientation_histogram] ERROR");
      $finish;
    end
  end

  // bin receiver: random stalls per beat, quiet stretches, one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (cycle_count % 256 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        rx_hold   = LONG_HOLD;
      end
      if (m_axis_tvalid && m_axis_tready) rx_wait = rx_quiet ? 0 : $urandom_range(0, 12);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(
    input logic [MAG_W-1:0] magnitude,
    input logic [ANG_W-1:0] angle,
    input logic             last_of_cell
  );
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, angle, magnitude};
    s_axis_tlast  <= last_of_cell;
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic send_random_cell(input int unsigned length);
    logic [MAG_W-1:0] magnitude;
    logic [ANG_W-1:0] angle;
    for (int i = 0; i < length; i++) begin
      case ($urandom_range(0, 15))
        0:       magnitude = '0;
        1:       magnitude = '1;
        default: magnitude = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 15))
        0:       angle = 15'(BIN_WIDTH * $urandom_range(0, 2 * BIN_COUNT - 1));
        1:       angle = 15'($urandom_range(23040, 32767));
        default: angle = 15'($urandom_range(0, 23039));
      endcase
      send_pixel(magnitude, angle, i == length - 1);
    end
  endtask

  initial begin
    bit pressure_done;
    int unsigned cell_length;
    pressure_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // extremes, fold above 180 and above 360, zero fraction, wrap past the last bin
    send_pixel(16'd0, 15'd0, 1'b0);
    send_pixel(16'hFFFF, 15'd0, 1'b0);
    send_pixel(16'hFFFF, 15'd11519, 1'b0);
    send_pixel(16'hFFFF, 15'd11520, 1'b0);
    send_pixel(16'hFFFF, 15'd23039, 1'b0);
    send_pixel(16'd1, 15'(BIN_WIDTH), 1'b0);
    send_pixel(16'hFFFF, 15'(BIN_WIDTH / 2), 1'b0);
    send_pixel(16'd12345, 15'h7FFF, 1'b1);
    send_pixel(16'hFFFF, 15'd16384, 1'b1);
    send_pixel(16'hAAAA, 15'h2AAA, 1'b0);
    send_pixel(16'h5555, 15'h1555, 1'b0);
    send_pixel(16'hFFFF, 15'd22400, 1'b1);
    for (int k = 0; k < BIN_COUNT; k++) begin
      send_pixel(16'hFFFF, 15'(BIN_WIDTH * k), k == BIN_COUNT - 1);
    end

    // drive one bin into saturation
    tx_quiet = 1'b1;
    for (int k = 0; k < 260; k++) send_pixel(16'hFFFF, 15'd0, k == 259);
    tx_quiet = 1'b0;
    wait_until_drained();

    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      if (!pressure_done && pixels_sent >= RANDOM_PIXELS / 2) begin
        pressure_done = 1'b1;
        hold_requests++;
        tx_quiet = 1'b1;
        repeat (4) send_random_cell(8);
        wait_until_drained();
        tx_quiet = 1'b0;
      end
      cell_length = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      send_random_cell(cell_length);
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[hog_cell_orientation_histogram] OK");
    end else begin
      $display("[hog_cell_orientation_histogram] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hog_pkg.sv
rtl/hog_cell_orientation_histogram.sv
tb/hog_cell_orientation_histogram_checker.sv
tb/hog_cell_orientation_histogram_test.sv
